### design/wmm_pkg.sv
// wmm_pkg: shared constants, state encoding and divider request type
// for the sliding-window min/max/mean block; no dependencies
package wmm_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int SAMPLE_W     = 12;
	localparam int COUNT_W      = 5;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W        = SAMPLE_W + ADDR_W;
	localparam int STEP_W       = $clog2(SUM_W + 1);
	localparam int IN_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 3 * SAMPLE_W + COUNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_START,
		ST_DIVIDE
	} wmm_state_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [FILL_W-1:0] divisor;
	} wmm_div_req_t;

endpackage

### design/wmm_ram.sv
// wmm_ram: sample ring storage, one write port and one registered read port
// depends on wmm_pkg
module wmm_ram (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [wmm_pkg::ADDR_W-1:0]    wr_addr,
	input  logic [wmm_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [wmm_pkg::ADDR_W-1:0]    rd_addr,
	output logic [wmm_pkg::SAMPLE_W-1:0]  rd_data
);
	import wmm_pkg::*;

	logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/wmm_div.sv
// wmm_div: restoring divider, one quotient bit per cycle
// depends on wmm_pkg
module wmm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wmm_pkg::wmm_div_req_t      req,
	output logic                       done,
	output logic [wmm_pkg::SUM_W-1:0]  quotient
);
	import wmm_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [SUM_W-1:0]    dvd_q;
	logic [FILL_W-1:0]   rem_q;
	logic [FILL_W-1:0]   dsr_q;
	logic [FILL_W:0]     rem_shift;
	logic [FILL_W:0]     diff;
	logic                fits;

	assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
	assign diff      = rem_shift - {1'b0, dsr_q};
	assign fits      = (rem_shift >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[FILL_W-1:0] : rem_shift[FILL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### design/window_min_max_mean_unit.sv
// window_min_max_mean_unit: top level of the sliding-window min/max/mean block
// depends on wmm_pkg, wmm_ram, wmm_div
//
//   channel | direction | fields (lsb first)
//   s_*     | in        | sample[11:0]
//   m_*     | out       | window_min[11:0], window_max[23:12],
//           |           | window_mean[35:24], valid_count[40:36]
//
// one sample passes through these steps in order: the idle state that takes
// and stores it, one ram read per valid entry, the drain state for the ram
// read latency of the min/max/sum scan, the divider start state, the
// bit-serial divider over SUM_W bits and the load of the result register
// s_tready is high only while idle; the result sits in the output register,
// so a new sample is taken while the previous result waits on m_tready
// reset clears the ring pointer and fill count; ring contents are not cleared
module window_min_max_mean_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wmm_pkg::IN_TDATA_W-1:0]    s_tdata,  // sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wmm_pkg::OUT_TDATA_W-1:0]   m_tdata   // window_min, window_max, window_mean, valid_count
);
	import wmm_pkg::*;

	wmm_state_t state_q;
	wmm_state_t state_d;

	// ring bookkeeping
	logic [ADDR_W-1:0]   wr_slot_q;
	logic [FILL_W-1:0]   filled_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   last_idx;

	// scan accumulators
	logic                rd_v_s1;
	logic [SAMPLE_W-1:0] rd_data;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SUM_W-1:0]    sum_q;

	// sequencer outputs
	logic                accept;
	logic                rd_en;
	logic                load_out;
	logic                out_free;
	logic                div_start;

	wmm_div_req_t        div_req;
	logic                div_done;
	logic [SUM_W-1:0]    div_quot;

	// output register
	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign last_idx = ADDR_W'(filled_q - FILL_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == last_idx) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done && out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		load_out  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_SCAN:   rd_en     = 1'b1;
			ST_START:  div_start = 1'b1;
			ST_DIVIDE: load_out  = div_done && out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign div_req = '{start: div_start, dividend: sum_q, divisor: filled_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wr_slot_q <= '0;
			filled_q  <= '0;
			idx_q     <= '0;
			rd_v_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (accept) begin
				// advance the ring pointer, wrap after the last slot
				wr_slot_q <= (wr_slot_q == ADDR_W'(WINDOW_DEPTH - 1)) ?
					'0 : wr_slot_q + ADDR_W'(1);
				// fill count saturates at the window depth
				if (filled_q != FILL_W'(WINDOW_DEPTH)) begin
					filled_q <= filled_q + FILL_W'(1);
				end
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
		end
	end

	// scan accumulators, one entry per cycle behind the ram read
	always_ff @(posedge clk) begin
		if (accept) begin
			min_q <= SAMPLE_MAX;
			max_q <= '0;
			sum_q <= '0;
		end else if (rd_v_s1) begin
			if (rd_data < min_q) min_q <= rd_data;
			if (rd_data > max_q) max_q <= rd_data;
			sum_q <= sum_q + SUM_W'(rd_data);
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= OUT_TDATA_W'({COUNT_W'(filled_q), SAMPLE_W'(div_quot), max_q, min_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	wmm_ram u_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wr_slot_q),
		.wr_data (s_tdata[SAMPLE_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	wmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

endmodule
